[sv/mhsa_pkg.sv]
// shared constants, codes and controller/datapath interface types
`timescale 1ns / 1ps
package mhsa_pkg;

    localparam int LOW_DEPTH   = 4096;
    localparam int HIGH_DEPTH  = 128;
    localparam int SMALL_DEPTH = 2;
    localparam int BIG_DEPTH   = 4096;

    localparam int AW_BITS = 25;

    localparam int LOW_CNT_W   = $clog2(LOW_DEPTH + 1);
    localparam int LOW_UW      = $clog2(LOW_DEPTH);
    localparam int HIGH_CNT_W  = $clog2(HIGH_DEPTH + 1);
    localparam int HIGH_AW     = $clog2(HIGH_DEPTH);
    localparam int SMALL_CNT_W = $clog2(SMALL_DEPTH + 1);
    localparam int BIG_CNT_W   = $clog2(BIG_DEPTH + 1);
    localparam int BIG_UW      = $clog2(BIG_DEPTH);

    localparam int IDX_W0 = (LOW_CNT_W > BIG_CNT_W) ? LOW_CNT_W : BIG_CNT_W;
    localparam int IDX_W1 = (IDX_W0 > HIGH_CNT_W) ? IDX_W0 : HIGH_CNT_W;
    localparam int IDX_W  = (IDX_W1 > SMALL_CNT_W) ? IDX_W1 : SMALL_CNT_W;

    // register file
    localparam int REG_COUNT = 5;
    localparam int PADDR_W   = 5;
    localparam logic [2:0] REG_LOW_BASE = 3'd0;
    localparam logic [2:0] REG_TOP_MEM  = 3'd1;
    localparam logic [2:0] REG_HEAP_A   = 3'd2;
    localparam logic [2:0] REG_HEAP_B   = 3'd3;
    localparam logic [2:0] REG_HEAP_C   = 3'd4;

    localparam logic [24:0] LOW_BASE_RST = 25'd16384;
    localparam logic [24:0] TOP_MEM_RST  = 25'd16777216;
    localparam logic [24:0] HEAP_A_RST   = 25'd1024;
    localparam logic [24:0] HEAP_B_RST   = 25'd1024;
    localparam logic [24:0] HEAP_C_RST   = 25'd1843200;
    localparam logic [24:0] BASE_A_RST   = TOP_MEM_RST - HEAP_A_RST;
    localparam logic [24:0] BASE_B_RST   = BASE_A_RST - HEAP_B_RST;
    localparam logic [24:0] BASE_C_RST   = BASE_B_RST - HEAP_C_RST;
    localparam logic [24:0] WM_RST       = 25'd16777216;

    // request modes
    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_FREE    = 2'd1;
    localparam logic [1:0] MODE_QUERY   = 2'd2;
    localparam logic [1:0] MODE_INVALID = 2'd3;

    // heap selects, also the scan order of the stacks
    localparam logic [2:0] SEL_LOW  = 3'd0;
    localparam logic [2:0] SEL_HIGH = 3'd1;
    localparam logic [2:0] SEL_A    = 3'd2;
    localparam logic [2:0] SEL_B    = 3'd3;
    localparam logic [2:0] SEL_C    = 3'd4;

    // result status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    typedef struct packed {
        logic accept;
        logic alloc;
        logic wm_upd;
        logic out_load;
        logic base_a_ld;
        logic base_b_ld;
        logic base_c_ld;
        logic scan_start;
        logic next_stack;
        logic idx_inc;
        logic rd_top;
        logic clr_used;
        logic pop;
        logic pop_end_empty;
        logic pop_end_used;
        logic prev_ld;
        logic size_high;
        logic size_up;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       idx_lt_cnt;
        logic       cnt_zero;
        logic       match;
        logic       used;
        logic       sid_high;
        logic       sid_last;
        logic       out_free;
    } stat_t;

endpackage

[sv/mhsa_ram.sv]
// generic single write, single registered read memory
`timescale 1ns / 1ps
module mhsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/mhsa_ctrl.sv]
// sequencing state machine for allocate, free, query and re-initialisation
`timescale 1ns / 1ps
module mhsa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           cfg_we,
    input  mhsa_pkg::stat_t st,
    output mhsa_pkg::cmd_t  cmd
);
    import mhsa_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DISP      = 4'd1;
    localparam logic [3:0] S_ALLOC     = 4'd2;
    localparam logic [3:0] S_WM        = 4'd3;
    localparam logic [3:0] S_DONE      = 4'd4;
    localparam logic [3:0] S_INIT_A    = 4'd5;
    localparam logic [3:0] S_INIT_B    = 4'd6;
    localparam logic [3:0] S_INIT_C    = 4'd7;
    localparam logic [3:0] S_F_SCAN_RD = 4'd8;
    localparam logic [3:0] S_F_SCAN_EV = 4'd9;
    localparam logic [3:0] S_F_POP_RD  = 4'd10;
    localparam logic [3:0] S_F_POP_EV  = 4'd11;
    localparam logic [3:0] S_Q_RD      = 4'd12;
    localparam logic [3:0] S_Q_EV      = 4'd13;
    localparam logic [3:0] S_Q_NX      = 4'd14;
    localparam logic [3:0] S_Q_NXEV    = 4'd15;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = (state_reg != S_IDLE) || cfg_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    state_next = S_INIT_A;
                end
                else if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (st.mode)
                    MODE_ALLOC:
                    begin
                        state_next = S_ALLOC;
                    end
                    MODE_FREE:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_F_SCAN_RD;
                    end
                    MODE_QUERY:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_Q_RD;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_ALLOC:
            begin
                cmd.alloc  = 1'b1;
                state_next = S_WM;
            end
            S_WM:
            begin
                cmd.wm_upd = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_INIT_A:
            begin
                cmd.base_a_ld = 1'b1;
                state_next    = cfg_we ? S_INIT_A : S_INIT_B;
            end
            S_INIT_B:
            begin
                cmd.base_b_ld = 1'b1;
                state_next    = cfg_we ? S_INIT_A : S_INIT_C;
            end
            S_INIT_C:
            begin
                cmd.base_c_ld = 1'b1;
                state_next    = cfg_we ? S_INIT_A : S_IDLE;
            end
            // free: in each stack find the first match, clear it, then pop freed tops
            S_F_SCAN_RD:
            begin
                state_next = st.idx_lt_cnt ? S_F_SCAN_EV : S_F_POP_RD;
            end
            S_F_SCAN_EV:
            begin
                if (st.match)
                begin
                    cmd.clr_used = 1'b1;
                    state_next   = S_F_POP_RD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_F_SCAN_RD;
                end
            end
            S_F_POP_RD:
            begin
                if (st.cnt_zero)
                begin
                    cmd.pop_end_empty = 1'b1;
                    if (st.sid_last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.next_stack = 1'b1;
                        state_next     = S_F_SCAN_RD;
                    end
                end
                else
                begin
                    cmd.rd_top = 1'b1;
                    state_next = S_F_POP_EV;
                end
            end
            S_F_POP_EV:
            begin
                if (!st.used)
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_F_POP_RD;
                end
                else
                begin
                    cmd.pop_end_used = 1'b1;
                    if (st.sid_last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.next_stack = 1'b1;
                        state_next     = S_F_SCAN_RD;
                    end
                end
            end
            // query: later stacks override earlier matches
            S_Q_RD:
            begin
                if (st.idx_lt_cnt)
                begin
                    state_next = S_Q_EV;
                end
                else if (st.sid_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.next_stack = 1'b1;
                    state_next     = S_Q_RD;
                end
            end
            S_Q_EV:
            begin
                if (st.match && st.sid_high)
                begin
                    cmd.size_high = 1'b1;
                    if (st.sid_last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.next_stack = 1'b1;
                        state_next     = S_Q_RD;
                    end
                end
                else if (st.match)
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_Q_NX;
                end
                else
                begin
                    cmd.prev_ld = 1'b1;
                    cmd.idx_inc = 1'b1;
                    state_next  = S_Q_RD;
                end
            end
            S_Q_NX:
            begin
                state_next = S_Q_NXEV;
            end
            S_Q_NXEV:
            begin
                cmd.size_up = 1'b1;
                if (st.sid_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.next_stack = 1'b1;
                    state_next     = S_Q_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[sv/mhsa_datapath.sv]
// stack storage, configuration registers, arithmetic and result registers
`timescale 1ns / 1ps
module mhsa_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  mhsa_pkg::cmd_t      cmd,
    output mhsa_pkg::stat_t     st,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_idx,
    input  logic [24:0]         cfg_wdata,
    output logic [24:0]         cfg_rdata,
    input  logic [1:0]          mode,
    input  logic [2:0]          heap_select,
    input  logic [24:0]         request_size,
    input  logic [24:0]         address,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [24:0]         result_address,
    output logic [24:0]         block_size,
    output logic [24:0]         unused_bytes,
    output logic [24:0]         min_unused,
    output logic [1:0]          status
);
    import mhsa_pkg::*;

    // configuration and derived bases
    logic [24:0] low_base_reg, top_mem_reg, a_size_reg, b_size_reg, c_size_reg;
    logic [24:0] base_a_reg, base_b_reg, base_c_reg;

    // stack control
    logic [LOW_CNT_W-1:0]   low_cnt_reg;
    logic [HIGH_CNT_W-1:0]  high_cnt_reg;
    logic [SMALL_CNT_W-1:0] small_cnt_reg [0:1];
    logic [BIG_CNT_W-1:0]   big_cnt_reg;
    logic [24:0]            low_top_reg, big_top_reg, hp_reg;
    logic [24:0]            small_top_reg [0:1];
    logic [24:0]            wm_reg;

    // fixed heaps a and b live in flops
    logic [24:0] small_addr_reg [0:1][0:SMALL_DEPTH];
    logic        small_used_reg [0:1][0:SMALL_DEPTH];

    // request and scan
    logic [1:0]       mode_reg;
    logic [2:0]       sel_reg;
    logic [25:0]      rounded_reg;
    logic [24:0]      p_reg;
    logic [2:0]       sid_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [24:0]      prev_reg;
    logic [24:0]      raddr_reg, bsize_reg;
    logic [1:0]       status_reg;
    logic             zero_d_reg;
    logic [24:0]      small_v_reg;
    logic             small_u_reg;

    logic        out_valid_reg;
    logic [24:0] res_addr_reg, res_size_reg, res_unused_reg, res_min_reg;
    logic [1:0]  res_status_reg;

    // memory read data
    logic [24:0] low_addr_q, high_addr_q, big_addr_q;
    logic        low_used_q, high_used_q, big_used_q;

    logic [IDX_W-1:0]       cnt_sel, rd_pos;
    logic [SMALL_CNT_W-1:0] rd_pos_s, idx_s;
    logic                   h_sid, h_sel;
    logic [24:0]            v;
    logic                   used_v;
    logic [24:0]            unused_now;

    // allocation
    logic [24:0] a_top, a_end;
    logic        a_full, a_valid, a_nospace, a_ok, alloc_do;
    logic [25:0] a_sum;
    logic [24:0] hp_new;
    logic [1:0]  a_status;

    // memory write ports
    logic                 low_addr_we, low_used_we, high_addr_we, high_used_we;
    logic                 big_addr_we, big_used_we;
    logic [LOW_UW-1:0]    low_used_wa;
    logic [HIGH_AW-1:0]   high_used_wa;
    logic [BIG_UW-1:0]    big_used_wa;

    logic [25:0] rounded_in;

    assign h_sid    = (sid_reg == SEL_B);
    assign h_sel    = (sel_reg == SEL_B);
    assign rd_pos_s = rd_pos[SMALL_CNT_W-1:0];
    assign idx_s    = idx_reg[SMALL_CNT_W-1:0];

    assign unused_now = (hp_reg > low_top_reg) ? (hp_reg - low_top_reg) : 25'd0;
    assign rounded_in = ({1'b0, request_size} + 26'd31) & ~26'd31;

    always_comb
    begin
        case (sid_reg)
            SEL_LOW:  cnt_sel = IDX_W'(low_cnt_reg);
            SEL_HIGH: cnt_sel = IDX_W'(high_cnt_reg);
            SEL_A:    cnt_sel = IDX_W'(small_cnt_reg[0]);
            SEL_B:    cnt_sel = IDX_W'(small_cnt_reg[1]);
            SEL_C:    cnt_sel = IDX_W'(big_cnt_reg);
            default:  cnt_sel = '0;
        endcase
    end

    assign rd_pos = cmd.rd_top ? (cnt_sel - IDX_W'(1)) : idx_reg;

    // entry value in the cycle after its read was issued
    always_comb
    begin
        case (sid_reg)
            SEL_LOW:
            begin
                v      = zero_d_reg ? low_base_reg : low_addr_q;
                used_v = low_used_q;
            end
            SEL_HIGH:
            begin
                v      = high_addr_q;
                used_v = high_used_q;
            end
            SEL_A:
            begin
                v      = zero_d_reg ? base_a_reg : small_v_reg;
                used_v = small_u_reg;
            end
            SEL_B:
            begin
                v      = zero_d_reg ? base_b_reg : small_v_reg;
                used_v = small_u_reg;
            end
            SEL_C:
            begin
                v      = zero_d_reg ? base_c_reg : big_addr_q;
                used_v = big_used_q;
            end
            default:
            begin
                v      = '0;
                used_v = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        st.mode       = mode_reg;
        st.idx_lt_cnt = (idx_reg < cnt_sel);
        st.cnt_zero   = (cnt_sel == '0);
        st.match      = (v == p_reg);
        st.used       = used_v;
        st.sid_high   = (sid_reg == SEL_HIGH);
        st.sid_last   = (sid_reg == SEL_C);
        st.out_free   = !out_valid_reg || !out_stall;
    end

    // allocation checks: heap select first, then space, then table depth
    always_comb
    begin
        a_valid = 1'b1;
        case (sel_reg)
            SEL_LOW:
            begin
                a_top  = low_top_reg;
                a_end  = hp_reg;
                a_full = (low_cnt_reg >= LOW_CNT_W'(LOW_DEPTH));
            end
            SEL_HIGH:
            begin
                a_top  = low_top_reg;
                a_end  = hp_reg;
                a_full = (high_cnt_reg >= HIGH_CNT_W'(HIGH_DEPTH));
            end
            SEL_A:
            begin
                a_top  = small_top_reg[0];
                a_end  = top_mem_reg;
                a_full = (small_cnt_reg[0] >= SMALL_CNT_W'(SMALL_DEPTH));
            end
            SEL_B:
            begin
                a_top  = small_top_reg[1];
                a_end  = base_a_reg;
                a_full = (small_cnt_reg[1] >= SMALL_CNT_W'(SMALL_DEPTH));
            end
            SEL_C:
            begin
                a_top  = big_top_reg;
                a_end  = base_b_reg;
                a_full = (big_cnt_reg >= BIG_CNT_W'(BIG_DEPTH));
            end
            default:
            begin
                a_top   = '0;
                a_end   = '0;
                a_full  = 1'b0;
                a_valid = 1'b0;
            end
        endcase
    end

    assign a_sum     = {1'b0, a_top} + rounded_reg;
    assign a_nospace = (a_sum > {1'b0, a_end});
    assign a_ok      = a_valid && !a_nospace && !a_full;
    assign alloc_do  = cmd.alloc && a_ok;
    assign hp_new    = 25'({1'b0, hp_reg} - rounded_reg);

    always_comb
    begin
        if (!a_valid)
        begin
            a_status = ST_INVALID;
        end
        else if (a_nospace)
        begin
            a_status = ST_NOSPACE;
        end
        else if (a_full)
        begin
            a_status = ST_FULL;
        end
        else
        begin
            a_status = ST_OK;
        end
    end

    assign low_addr_we  = alloc_do && (sel_reg == SEL_LOW);
    assign low_used_we  = low_addr_we || (cmd.clr_used && (sid_reg == SEL_LOW));
    assign low_used_wa  = cmd.alloc ? low_cnt_reg[LOW_UW-1:0] : idx_reg[LOW_UW-1:0];
    assign high_addr_we = alloc_do && (sel_reg == SEL_HIGH);
    assign high_used_we = high_addr_we || (cmd.clr_used && (sid_reg == SEL_HIGH));
    assign high_used_wa = cmd.alloc ? high_cnt_reg[HIGH_AW-1:0] : idx_reg[HIGH_AW-1:0];
    assign big_addr_we  = alloc_do && (sel_reg == SEL_C);
    assign big_used_we  = big_addr_we || (cmd.clr_used && (sid_reg == SEL_C));
    assign big_used_wa  = cmd.alloc ? big_cnt_reg[BIG_UW-1:0] : idx_reg[BIG_UW-1:0];

    mhsa_ram #(.WIDTH(25), .DEPTH(LOW_DEPTH + 1)) u_low_addr (
        .clk     (clk),
        .wr_en   (low_addr_we),
        .wr_addr (LOW_CNT_W'(low_cnt_reg + LOW_CNT_W'(1))),
        .wr_data (a_sum[24:0]),
        .rd_addr (rd_pos[LOW_CNT_W-1:0]),
        .rd_data (low_addr_q)
    );

    mhsa_ram #(.WIDTH(1), .DEPTH(LOW_DEPTH)) u_low_used (
        .clk     (clk),
        .wr_en   (low_used_we),
        .wr_addr (low_used_wa),
        .wr_data (cmd.alloc),
        .rd_addr (rd_pos[LOW_UW-1:0]),
        .rd_data (low_used_q)
    );

    mhsa_ram #(.WIDTH(25), .DEPTH(HIGH_DEPTH)) u_high_addr (
        .clk     (clk),
        .wr_en   (high_addr_we),
        .wr_addr (high_cnt_reg[HIGH_AW-1:0]),
        .wr_data (hp_new),
        .rd_addr (rd_pos[HIGH_AW-1:0]),
        .rd_data (high_addr_q)
    );

    mhsa_ram #(.WIDTH(1), .DEPTH(HIGH_DEPTH)) u_high_used (
        .clk     (clk),
        .wr_en   (high_used_we),
        .wr_addr (high_used_wa),
        .wr_data (cmd.alloc),
        .rd_addr (rd_pos[HIGH_AW-1:0]),
        .rd_data (high_used_q)
    );

    mhsa_ram #(.WIDTH(25), .DEPTH(BIG_DEPTH + 1)) u_big_addr (
        .clk     (clk),
        .wr_en   (big_addr_we),
        .wr_addr (BIG_CNT_W'(big_cnt_reg + BIG_CNT_W'(1))),
        .wr_data (a_sum[24:0]),
        .rd_addr (rd_pos[BIG_CNT_W-1:0]),
        .rd_data (big_addr_q)
    );

    mhsa_ram #(.WIDTH(1), .DEPTH(BIG_DEPTH)) u_big_used (
        .clk     (clk),
        .wr_en   (big_used_we),
        .wr_addr (big_used_wa),
        .wr_data (cmd.alloc),
        .rd_addr (rd_pos[BIG_UW-1:0]),
        .rd_data (big_used_q)
    );

    always_comb
    begin
        case (cfg_idx)
            REG_LOW_BASE: cfg_rdata = low_base_reg;
            REG_TOP_MEM:  cfg_rdata = top_mem_reg;
            REG_HEAP_A:   cfg_rdata = a_size_reg;
            REG_HEAP_B:   cfg_rdata = b_size_reg;
            REG_HEAP_C:   cfg_rdata = c_size_reg;
            default:      cfg_rdata = '0;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_base_reg     <= LOW_BASE_RST;
            top_mem_reg      <= TOP_MEM_RST;
            a_size_reg       <= HEAP_A_RST;
            b_size_reg       <= HEAP_B_RST;
            c_size_reg       <= HEAP_C_RST;
            base_a_reg       <= BASE_A_RST;
            base_b_reg       <= BASE_B_RST;
            base_c_reg       <= BASE_C_RST;
            low_cnt_reg      <= '0;
            high_cnt_reg     <= '0;
            small_cnt_reg[0] <= '0;
            small_cnt_reg[1] <= '0;
            big_cnt_reg      <= '0;
            low_top_reg      <= LOW_BASE_RST;
            small_top_reg[0] <= BASE_A_RST;
            small_top_reg[1] <= BASE_B_RST;
            big_top_reg      <= BASE_C_RST;
            hp_reg           <= BASE_C_RST;
            wm_reg           <= WM_RST;
            sid_reg          <= SEL_LOW;
            idx_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_LOW_BASE: low_base_reg <= cfg_wdata;
                    REG_TOP_MEM:  top_mem_reg  <= cfg_wdata;
                    REG_HEAP_A:   a_size_reg   <= cfg_wdata;
                    REG_HEAP_B:   b_size_reg   <= cfg_wdata;
                    REG_HEAP_C:   c_size_reg   <= cfg_wdata;
                    default:      low_base_reg <= low_base_reg;
                endcase
            end

            if (cmd.base_a_ld)
            begin
                base_a_reg <= (top_mem_reg > a_size_reg) ? (top_mem_reg - a_size_reg) : 25'd0;
            end
            if (cmd.base_b_ld)
            begin
                base_b_reg <= (base_a_reg > b_size_reg) ? (base_a_reg - b_size_reg) : 25'd0;
            end

            if (cmd.base_c_ld)
            begin
                base_c_reg       <= (base_b_reg > c_size_reg) ? (base_b_reg - c_size_reg)
                                                              : 25'd0;
                hp_reg           <= (base_b_reg > c_size_reg) ? (base_b_reg - c_size_reg)
                                                              : 25'd0;
                big_top_reg      <= (base_b_reg > c_size_reg) ? (base_b_reg - c_size_reg)
                                                              : 25'd0;
                low_cnt_reg      <= '0;
                high_cnt_reg     <= '0;
                small_cnt_reg[0] <= '0;
                small_cnt_reg[1] <= '0;
                big_cnt_reg      <= '0;
                low_top_reg      <= low_base_reg;
                small_top_reg[0] <= base_a_reg;
                small_top_reg[1] <= base_b_reg;
            end

            if (alloc_do)
            begin
                case (sel_reg)
                    SEL_LOW:
                    begin
                        low_cnt_reg <= low_cnt_reg + LOW_CNT_W'(1);
                        low_top_reg <= a_sum[24:0];
                    end
                    SEL_HIGH:
                    begin
                        high_cnt_reg <= high_cnt_reg + HIGH_CNT_W'(1);
                        hp_reg       <= hp_new;
                    end
                    SEL_A, SEL_B:
                    begin
                        small_cnt_reg[h_sel] <= small_cnt_reg[h_sel] + SMALL_CNT_W'(1);
                        small_top_reg[h_sel] <= a_sum[24:0];
                    end
                    SEL_C:
                    begin
                        big_cnt_reg <= big_cnt_reg + BIG_CNT_W'(1);
                        big_top_reg <= a_sum[24:0];
                    end
                    default:
                    begin
                        big_cnt_reg <= big_cnt_reg;
                    end
                endcase
            end

            if (cmd.pop)
            begin
                case (sid_reg)
                    SEL_LOW:
                    begin
                        low_cnt_reg <= low_cnt_reg - LOW_CNT_W'(1);
                        low_top_reg <= v;
                    end
                    SEL_HIGH:
                    begin
                        high_cnt_reg <= high_cnt_reg - HIGH_CNT_W'(1);
                    end
                    SEL_A, SEL_B:
                    begin
                        small_cnt_reg[h_sid] <= small_cnt_reg[h_sid] - SMALL_CNT_W'(1);
                        small_top_reg[h_sid] <= v;
                    end
                    SEL_C:
                    begin
                        big_cnt_reg <= big_cnt_reg - BIG_CNT_W'(1);
                        big_top_reg <= v;
                    end
                    default:
                    begin
                        big_cnt_reg <= big_cnt_reg;
                    end
                endcase
            end

            // top-down pointer follows its top entry after a free, or base c when empty
            if (cmd.pop_end_used && (sid_reg == SEL_HIGH))
            begin
                hp_reg <= v;
            end
            if (cmd.pop_end_empty && (sid_reg == SEL_HIGH))
            begin
                hp_reg <= base_c_reg;
            end

            if (cmd.wm_upd && (unused_now < wm_reg))
            begin
                wm_reg <= unused_now;
            end

            if (cmd.scan_start)
            begin
                sid_reg <= SEL_LOW;
                idx_reg <= '0;
            end
            else if (cmd.next_stack)
            begin
                sid_reg <= sid_reg + 3'd1;
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        zero_d_reg  <= (rd_pos == '0);
        small_v_reg <= small_addr_reg[h_sid][rd_pos_s];
        small_u_reg <= small_used_reg[h_sid][rd_pos_s];

        if (alloc_do && ((sel_reg == SEL_A) || (sel_reg == SEL_B)))
        begin
            small_addr_reg[h_sel][SMALL_CNT_W'(small_cnt_reg[h_sel] + SMALL_CNT_W'(1))]
                <= a_sum[24:0];
            small_used_reg[h_sel][small_cnt_reg[h_sel]] <= 1'b1;
        end
        if (cmd.clr_used && ((sid_reg == SEL_A) || (sid_reg == SEL_B)))
        begin
            small_used_reg[h_sid][idx_s] <= 1'b0;
        end

        if (cmd.accept)
        begin
            mode_reg    <= mode;
            sel_reg     <= heap_select;
            rounded_reg <= rounded_in;
            p_reg       <= address;
            raddr_reg   <= '0;
            bsize_reg   <= '0;
            status_reg  <= (mode == MODE_INVALID) ? ST_INVALID : ST_OK;
        end
        if (cmd.alloc)
        begin
            status_reg <= a_status;
            raddr_reg  <= a_ok ? ((sel_reg == SEL_HIGH) ? hp_new : a_top) : 25'd0;
        end
        if (cmd.scan_start || cmd.next_stack)
        begin
            prev_reg <= base_c_reg;
        end
        else if (cmd.prev_ld)
        begin
            prev_reg <= v;
        end
        if (cmd.size_high)
        begin
            bsize_reg <= prev_reg - p_reg;
        end
        if (cmd.size_up)
        begin
            bsize_reg <= v - p_reg;
        end

        if (cmd.out_load)
        begin
            res_addr_reg   <= raddr_reg;
            res_size_reg   <= bsize_reg;
            res_unused_reg <= unused_now;
            res_min_reg    <= wm_reg;
            res_status_reg <= status_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_address = res_addr_reg;
    assign block_size     = res_size_reg;
    assign unused_bytes   = res_unused_reg;
    assign min_unused     = res_min_reg;
    assign status         = res_status_reg;

endmodule

[sv/multi_heap_stack_allocator_unit.sv]
// top level of the multi-heap stack allocator
`timescale 1ns / 1ps
// usage
//  requests come in on in_valid/in_stall with mode, heap_select, request_size
//  and address; one result per request leaves on out_valid/out_stall
//  a request is taken when in_valid is high and in_stall is low
//  allocate passes through the dispatch, allocate, watermark and done states;
//  invalid mode goes from dispatch straight to done; free walks all five
//  stacks, per stack reading each entry up to the match, clearing it, then
//  popping freed tops until a used top or an empty stack; query walks each
//  stack up to its first match and, in an upward stack, reads the entry above it
//  the walk is paced by the single read port of each entry memory: the
//  controller reads an entry, then checks it; one request is in flight at once
//  the result sits in an output register: while the receiver stalls, the next
//  request is still taken and worked on, and waits only to load its result
//  reset clears the counts, restores the register defaults and the bases
//  derived from them, and sets the low watermark to 16 MiB
//  a register write through the apb port made while no request is in progress
//  re-initialises every stack in the init a, b and c states, with in_stall high
module multi_heap_stack_allocator_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    // request channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   mode,
    input  logic [2:0]                   heap_select,
    input  logic [24:0]                  request_size,
    input  logic [24:0]                  address,
    // result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [24:0]                  result_address,
    output logic [24:0]                  block_size,
    output logic [24:0]                  unused_bytes,
    output logic [24:0]                  min_unused,
    output logic [1:0]                   status,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mhsa_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import mhsa_pkg::*;

    cmd_t        cmd;
    stat_t       st;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [24:0] cfg_rdata;

    // register index is the word address; writes past the list are dropped
    assign cfg_idx = paddr[4:2];
    assign cfg_we  = psel && penable && pwrite && (cfg_idx < 3'(REG_COUNT));
    assign pready  = 1'b1;
    assign prdata  = {7'd0, cfg_rdata};

    mhsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cfg_we   (cfg_we),
        .st       (st),
        .cmd      (cmd)
    );

    mhsa_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .cfg_we         (cfg_we),
        .cfg_idx        (cfg_idx),
        .cfg_wdata      (pwdata[24:0]),
        .cfg_rdata      (cfg_rdata),
        .mode           (mode),
        .heap_select    (heap_select),
        .request_size   (request_size),
        .address        (address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_address (result_address),
        .block_size     (block_size),
        .unused_bytes   (unused_bytes),
        .min_unused     (min_unused),
        .status         (status)
    );

endmodule

[sim/tb_top.sv]
// self-checking testbench for the multi-heap stack allocator
`timescale 1ns / 1ps
module tb_top;
    import mhsa_pkg::*;

    // clock, reset and cycle limit
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   cycle_cnt = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // block ports
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  mode = MODE_ALLOC;
    logic [2:0]  heap_select = SEL_LOW;
    logic [24:0] request_size = '0;
    logic [24:0] address = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [24:0] result_address, block_size, unused_bytes, min_unused;
    logic [1:0]  status;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    multi_heap_stack_allocator_unit dut (.*);

    // one expected result
    typedef struct packed {
        logic [24:0] raddr;
        logic [24:0] bsize;
        logic [24:0] unused;
        logic [24:0] wmark;
        logic [1:0]  st;
    } alloc_result_t;

    alloc_result_t pending_results[$];
    int unsigned   live_addrs[$];
    int            mismatch_cnt = 0;
    int            hold_left = 0;

    // predictor state: upward stacks 0 bottom-up, 1 heap a, 2 heap b, 3 heap c
    int unsigned cfg_low_base, cfg_top, cfg_a, cfg_b, cfg_c;
    int unsigned up_addr [4][0:BIG_DEPTH];
    bit          up_used [4][0:BIG_DEPTH-1];
    int unsigned up_cnt  [4];
    int unsigned up_depth[4] = '{LOW_DEPTH, SMALL_DEPTH, SMALL_DEPTH, BIG_DEPTH};
    int unsigned down_addr[0:HIGH_DEPTH-1];
    bit          down_used[0:HIGH_DEPTH-1];
    int unsigned down_cnt, down_ptr, watermark;

    function automatic int unsigned clamp_sub(int unsigned x, int unsigned y);
        return (x > y) ? x - y : 0;
    endfunction

    // rebuild every stack from the current registers, watermark survives
    function automatic void rebuild_heaps();
        int unsigned ba, bb, bc;
        ba = clamp_sub(cfg_top, cfg_a);
        bb = clamp_sub(ba, cfg_b);
        bc = clamp_sub(bb, cfg_c);
        for (int k = 0; k < 4; k++) up_cnt[k] = 0;
        down_cnt = 0;
        up_addr[0][0] = cfg_low_base;
        up_addr[1][0] = ba;
        up_addr[2][0] = bb;
        up_addr[3][0] = bc;
        down_ptr = bc;
    endfunction

    function automatic int unsigned gap_now();
        return clamp_sub(down_ptr, up_addr[0][up_cnt[0]]);
    endfunction

    function automatic void up_alloc(int k, longint unsigned stack_end,
                                     longint unsigned rsz, ref alloc_result_t r);
        int unsigned n;
        n = up_cnt[k];
        if (longint'(up_addr[k][n]) + rsz > stack_end) r.st = ST_NOSPACE;
        else if (n >= up_depth[k]) r.st = ST_FULL;
        else
        begin
            r.raddr = up_addr[k][n];
            up_used[k][n] = 1'b1;
            up_addr[k][n+1] = up_addr[k][n] + int'(rsz);
            up_cnt[k] = n + 1;
        end
    endfunction

    // works out the result of one accepted request and updates the state
    function automatic alloc_result_t allocator_step(logic [1:0] m, logic [2:0] s,
                                                     logic [24:0] sz, logic [24:0] a);
        alloc_result_t   r;
        longint unsigned rsz;
        int unsigned     bs;
        r = '0;
        bs = 0;
        rsz = (longint'(sz) + 31) & ~64'd31;
        if (m == MODE_ALLOC)
        begin
            case (s)
                SEL_LOW: up_alloc(0, down_ptr, rsz, r);
                SEL_HIGH:
                begin
                    if (longint'(up_addr[0][up_cnt[0]]) + rsz > down_ptr) r.st = ST_NOSPACE;
                    else if (down_cnt >= HIGH_DEPTH) r.st = ST_FULL;
                    else
                    begin
                        down_ptr = down_ptr - int'(rsz);
                        down_addr[down_cnt] = down_ptr;
                        down_used[down_cnt] = 1'b1;
                        down_cnt++;
                        r.raddr = down_ptr;
                    end
                end
                SEL_A: up_alloc(1, cfg_top, rsz, r);
                SEL_B: up_alloc(2, up_addr[1][0], rsz, r);
                SEL_C: up_alloc(3, up_addr[2][0], rsz, r);
                default: r.st = ST_INVALID;
            endcase
            if (gap_now() < watermark) watermark = gap_now();
            if (r.st == ST_OK && live_addrs.size() < 64) live_addrs.push_back(r.raddr);
        end
        else if (m == MODE_FREE)
        begin
            for (int k = 0; k < 4; k++)
            begin
                for (int i = 0; i < up_cnt[k]; i++)
                    if (up_addr[k][i] == a)
                    begin
                        up_used[k][i] = 1'b0;
                        break;
                    end
                while (up_cnt[k] > 0 && !up_used[k][up_cnt[k]-1]) up_cnt[k]--;
            end
            for (int i = 0; i < down_cnt; i++)
                if (down_addr[i] == a)
                begin
                    down_used[i] = 1'b0;
                    break;
                end
            while (down_cnt > 0 && !down_used[down_cnt-1]) down_cnt--;
            down_ptr = down_cnt ? down_addr[down_cnt-1] : up_addr[3][0];
        end
        else if (m == MODE_QUERY)
        begin
            // later stacks override earlier matches: bottom-up, top-down, a, b, c
            for (int i = 0; i < up_cnt[0]; i++)
                if (up_addr[0][i] == a)
                begin
                    bs = up_addr[0][i+1] - up_addr[0][i];
                    break;
                end
            for (int i = 0; i < down_cnt; i++)
                if (down_addr[i] == a)
                begin
                    bs = (i ? down_addr[i-1] : up_addr[3][0]) - down_addr[i];
                    break;
                end
            for (int k = 1; k < 4; k++)
                for (int i = 0; i < up_cnt[k]; i++)
                    if (up_addr[k][i] == a)
                    begin
                        bs = up_addr[k][i+1] - up_addr[k][i];
                        break;
                    end
            r.bsize = bs[24:0];
        end
        else r.st = ST_INVALID;
        r.unused = gap_now();
        r.wmark = watermark;
        return r;
    endfunction

    // cycle limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            alloc_result_t e;
            if (pending_results.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected result at cycle %0d", cycle_cnt);
            end
            else
            begin
                e = pending_results.pop_front();
                if (result_address !== e.raddr || block_size !== e.bsize ||
                    unused_bytes !== e.unused || min_unused !== e.wmark || status !== e.st)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp addr %0d size %0d unused %0d min %0d st %0d, got %0d %0d %0d %0d %0d",
                                 e.raddr, e.bsize, e.unused, e.wmark, e.st,
                                 result_address, block_size, unused_bytes, min_unused, status);
                end
            end
        end
    end

    // receiver stall: quiet stretches, short stalls, occasional long ones, forced holds
    initial
    begin
        int quiet, busy;
        quiet = 0;
        busy = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else if (busy > 0)
            begin
                out_stall = 1'b1;
                busy--;
            end
            else if (quiet > 0)
            begin
                out_stall = 1'b0;
                quiet--;
            end
            else
            begin
                out_stall = 1'b0;
                quiet = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
                busy = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
            end
        end
    end

    // send one request and predict its result at acceptance
    task automatic send_request(logic [1:0] m, logic [2:0] s, logic [24:0] sz,
                                logic [24:0] a, int gap);
        @(negedge clk);
        in_valid = 1'b1;
        mode = m;
        heap_select = s;
        request_size = sz;
        address = a;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(allocator_step(m, s, sz, a));
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        return ($urandom_range(0, 12) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
    endfunction

    // wait for every expected result, then let the block settle
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // register write: setup cycle then access cycle
    task automatic write_reg(logic [2:0] idx, int unsigned val);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_LOW_BASE: cfg_low_base = val & 32'h1FFFFFF;
            REG_TOP_MEM:  cfg_top = val & 32'h1FFFFFF;
            REG_HEAP_A:   cfg_a = val & 32'h1FFFFFF;
            REG_HEAP_B:   cfg_b = val & 32'h1FFFFFF;
            default:      cfg_c = val & 32'h1FFFFFF;
        endcase
        rebuild_heaps();
        live_addrs.delete();
    endtask

    task automatic set_layout(int unsigned lb, int unsigned top, int unsigned a,
                              int unsigned b, int unsigned c);
        wait_drained();
        write_reg(REG_LOW_BASE, lb);
        write_reg(REG_TOP_MEM, top);
        write_reg(REG_HEAP_A, a);
        write_reg(REG_HEAP_B, b);
        write_reg(REG_HEAP_C, c);
    endtask

    function automatic logic [24:0] pick_addr();
        if (live_addrs.size() != 0 && $urandom_range(0, 4) != 0)
            return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
        return $urandom_range(0, 32'h1FFFFFF);
    endfunction

    // one random request, mostly well formed
    task automatic random_request();
        int          pick;
        logic [24:0] sz;
        pick = $urandom_range(0, 99);
        sz = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32'h1FFFFFF) : $urandom_range(0, 300);
        if (pick < 50)
            send_request(MODE_ALLOC, ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                         : $urandom_range(0, 4), sz, $urandom_range(0, 32'h1FFFFFF), pick_gap());
        else if (pick < 75)
            send_request(MODE_FREE, $urandom_range(0, 7), sz, pick_addr(), pick_gap());
        else if (pick < 95)
            send_request(MODE_QUERY, $urandom_range(0, 7), sz, pick_addr(), pick_gap());
        else
            send_request(MODE_INVALID, $urandom_range(0, 7), sz, pick_addr(), pick_gap());
    endtask

    // extremes of the fields, every mode, out of space, table full, invalid heap
    task automatic test_directed();
        logic [24:0] first;
        send_request(MODE_ALLOC, SEL_LOW, 25'd0, '0, 0);
        send_request(MODE_ALLOC, SEL_LOW, 25'd1, '0, 1);
        send_request(MODE_ALLOC, SEL_HIGH, 25'd31, '0, 0);
        send_request(MODE_ALLOC, SEL_HIGH, 25'd32, '0, 2);
        send_request(MODE_ALLOC, SEL_LOW, 25'h1FFFFFF, 25'h1FFFFFF, 0);
        send_request(MODE_ALLOC, SEL_A, 25'd500, '0, 0);
        send_request(MODE_ALLOC, SEL_A, 25'd500, '0, 0);
        send_request(MODE_ALLOC, SEL_A, 25'd0, '0, 0);
        send_request(MODE_ALLOC, SEL_B, 25'd1025, '0, 0);
        send_request(MODE_ALLOC, SEL_C, 25'd4000, '0, 0);
        send_request(MODE_ALLOC, 3'd5, 25'd32, '0, 0);
        send_request(MODE_ALLOC, 3'd7, 25'd32, '0, 0);
        send_request(MODE_INVALID, SEL_LOW, 25'd32, '0, 0);
        first = live_addrs[0];
        send_request(MODE_QUERY, 3'd7, '0, first, 0);
        send_request(MODE_QUERY, SEL_LOW, '0, live_addrs[2], 0);
        send_request(MODE_QUERY, SEL_LOW, '0, 25'h1FFFFFF, 0);
        // free everything so stacks pop back to empty
        while (live_addrs.size() != 0)
            send_request(MODE_FREE, $urandom_range(0, 7), '0, live_addrs.pop_back(), 0);
        send_request(MODE_QUERY, SEL_LOW, '0, first, 0);
    endtask

    // fill the top-down stack past its depth, then release part of it
    task automatic test_top_down_full();
        int unsigned grabbed[$];
        set_layout(16384, 16777216, 1024, 1024, 1843200);
        repeat (HIGH_DEPTH + 3)
            send_request(MODE_ALLOC, SEL_HIGH, $urandom_range(0, 64), '0, pick_gap());
        grabbed = live_addrs;
        grabbed.shuffle();
        for (int i = 0; i < 8 && i < grabbed.size(); i++)
            send_request(MODE_FREE, SEL_HIGH, '0, grabbed[i], ($urandom_range(0, 3) == 0));
    endtask

    // all bases collapse to zero so one address matches in several stacks
    task automatic test_overlap();
        set_layout(0, 0, 0, 0, 0);
        send_request(MODE_ALLOC, SEL_LOW, 25'd0, '0, 0);
        send_request(MODE_ALLOC, SEL_A, 25'd0, '0, 0);
        send_request(MODE_ALLOC, SEL_C, 25'd0, '0, 0);
        send_request(MODE_ALLOC, SEL_HIGH, 25'd1, '0, 0);
        send_request(MODE_QUERY, SEL_LOW, '0, '0, 0);
        send_request(MODE_FREE, SEL_LOW, '0, '0, 0);
        send_request(MODE_QUERY, SEL_LOW, '0, '0, 0);
        set_layout(32'h1FFFFFF, 32'h1FFFFFF, 32'h1FFFFFF, 0, 16777216);
        send_request(MODE_ALLOC, SEL_B, 25'd64, '0, 0);
        send_request(MODE_ALLOC, SEL_LOW, 25'd0, '0, 0);
    endtask

    // receiver holds off while requests keep coming, then the sender waits
    task automatic test_backpressure();
        set_layout(1000, 8000, 64, 96, 2000);
        @(negedge clk);
        hold_left = 300;
        repeat (10) random_request();
        wait_drained();
    endtask

    // random traffic over the default layout and three small random layouts
    task automatic test_random();
        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase == 0) set_layout(16384, 16777216, 1024, 1024, 1843200);
            else set_layout($urandom_range(0, 4000), $urandom_range(6000, 16000),
                            $urandom_range(0, 200), $urandom_range(0, 200),
                            $urandom_range(0, 3000));
            repeat (6) random_request();
        end
    endtask

    initial
    begin
        cfg_low_base = LOW_BASE_RST;
        cfg_top = TOP_MEM_RST;
        cfg_a = HEAP_A_RST;
        cfg_b = HEAP_B_RST;
        cfg_c = HEAP_C_RST;
        watermark = WM_RST;
        rebuild_heaps();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_top_down_full();
        test_overlap();
        test_backpressure();
        test_random();
        wait_drained();
        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
